@@ src/ang_pkg.sv @@
// types, constants and control program for the audio noise gate
`timescale 1ns / 1ps

package ang_pkg;

    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = 24;
    localparam int GAIN_W     = 17;
    localparam int GAIN_FRAC  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd4;

    localparam int RST_THRESHOLD = 14917;
    localparam int RST_HOLD      = 1920;

    localparam logic [COEF_W-1:0] RST_ATTACK  = 24'd16707458;
    localparam logic [COEF_W-1:0] RST_RELEASE = 24'd16774304;
    localparam logic [GAIN_W-1:0] RST_FLOOR   = 17'd66;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_MUL_ENV  = 3'd1,
        S_LD_ENV   = 3'd2,
        S_MUL_GAIN = 3'd3,
        S_LD_GAIN  = 3'd4,
        S_MUL_OUT  = 3'd5,
        S_LD_OUT   = 3'd6
    } step_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_ENV  = 2'd1,
        MUL_GAIN = 2'd2,
        MUL_OUT  = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        C_NONE = 2'd0,
        C_IN   = 2'd1,
        C_OUT  = 2'd2
    } cond_t;

    typedef struct packed {
        step_t    next_step;
        cond_t    wait_on;
        logic     take_in;
        mul_sel_t mul_sel;
        logic     ld_env;
        logic     ld_gain;
        logic     ld_out;
    } ucode_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     ld_in;
        logic     ld_env;
        logic     ld_gain;
        logic     ld_out;
    } ctrl_t;

    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        w = '{next_step: S_IDLE, wait_on: C_NONE, take_in: 1'b0, mul_sel: MUL_NONE,
              ld_env: 1'b0, ld_gain: 1'b0, ld_out: 1'b0};
        unique case (addr)
            S_IDLE:
            begin
                w.next_step = S_MUL_ENV;
                w.wait_on   = C_IN;
                w.take_in   = 1'b1;
            end
            S_MUL_ENV:
            begin
                w.next_step = S_LD_ENV;
                w.mul_sel   = MUL_ENV;
            end
            S_LD_ENV:
            begin
                w.next_step = S_MUL_GAIN;
                w.ld_env    = 1'b1;
            end
            S_MUL_GAIN:
            begin
                w.next_step = S_LD_GAIN;
                w.mul_sel   = MUL_GAIN;
            end
            S_LD_GAIN:
            begin
                w.next_step = S_MUL_OUT;
                w.ld_gain   = 1'b1;
            end
            S_MUL_OUT:
            begin
                w.next_step = S_LD_OUT;
                w.mul_sel   = MUL_OUT;
            end
            S_LD_OUT:
            begin
                w.next_step = S_IDLE;
                w.wait_on   = C_OUT;
                w.ld_out    = 1'b1;
            end
            default:
            begin
                w.next_step = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/audio_noise_gate_unit.sv @@
// audio noise gate top level: microcode sequencer and datapath
`timescale 1ns / 1ps

// noise gate with hold and range for signed audio samples.
// input channel: in_valid / in_stall with sample_in; one beat is one sample.
// output channel: out_valid / out_stall with sample_out; one beat per input beat,
// in the same order.
// settings: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. index 0 threshold, 1 attack, 2 release, 3 hold length, 4 floor gain;
// other indexes are ignored. write settings only while no sample is in flight.
// a seven-step control program runs once per sample over one shared multiplier:
// envelope product, envelope and hold update, gain product, gain update,
// output product, output load. a new sample is taken only when the program is back
// at its idle step, after the output load; the multiplier is used by three
// dependent products per sample.
// the output register frees the datapath, so the block waits only when a new
// result is ready while the previous beat is still stalled.
// reset puts the program at its idle step, clears the envelope and hold count,
// sets the gain to unity and loads the default settings.
module audio_noise_gate_unit #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int HOLD_WIDTH   = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ang_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ang_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ang_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t uword;
    ctrl_t  ctrl;
    logic   advance;
    logic   out_free;

    assign uword = ucode_rom(step_reg);

    // next step
    always_comb
    begin
        unique case (uword.wait_on)
            C_IN:    advance = in_valid;
            C_OUT:   advance = out_free;
            default: advance = 1'b1;
        endcase
        step_next = advance ? uword.next_step : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_IDLE;
        else
            step_reg <= step_next;
    end

    // datapath strobes
    always_comb
    begin
        ctrl.mul_sel = uword.mul_sel;
        ctrl.ld_in   = uword.take_in && in_valid;
        ctrl.ld_env  = uword.ld_env;
        ctrl.ld_gain = uword.ld_gain;
        ctrl.ld_out  = uword.ld_out && out_free;
        in_stall     = !uword.take_in;
    end

    assign cfg_ready = 1'b1;

    ang_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .HOLD_WIDTH   (HOLD_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .out_stall  (out_stall),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

`ifndef ASSERT_OFF
    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (step_reg == S_MUL_ENV && in_stall))
        else $error("input beat did not start the program");

    a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step_reg == S_LD_OUT))
        else $error("output beat raised outside the output step");

    a_busy_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != S_IDLE) |-> in_stall)
        else $error("input taken while a sample is in flight");
`endif

endmodule

@@ src/ang_datapath.sv @@
// noise gate datapath: settings, envelope, hold, gain, shared multiplier, output register
`timescale 1ns / 1ps

module ang_datapath #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int HOLD_WIDTH   = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ang_pkg::ctrl_t                       ctrl,
    input  logic                                 cfg_we,
    input  logic [ang_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ang_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic                                 out_stall,
    output logic                                 out_free,
    output logic                                 out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out
);
    import ang_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int MAG_W  = SW - 1;
    localparam int MA_W   = (SW > GAIN_W + 1) ? SW : GAIN_W + 1;
    localparam int MB_W   = COEF_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int R_W    = PROD_W - GAIN_FRAC;

    localparam logic [PROD_W-1:0] HALF_COEF = PROD_W'(1) << (COEF_FRAC - 1);
    localparam logic [PROD_W-1:0] HALF_GAIN = PROD_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [R_W-1:0] OUT_MAX = {{(R_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};
    localparam logic signed [R_W-1:0] OUT_MIN = {{(R_W-MAG_W){1'b1}}, {MAG_W{1'b0}}};

    logic [MAG_W-1:0]       thr_reg;
    logic [COEF_W-1:0]      attack_reg;
    logic [COEF_W-1:0]      release_reg;
    logic [HOLD_WIDTH-1:0]  hold_len_reg;
    logic [GAIN_W-1:0]      floor_reg;

    logic signed [SW-1:0]   sample_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [MAG_W-1:0]       envelope_reg;
    logic [MAG_W-1:0]       envelope_next;
    logic [HOLD_WIDTH-1:0]  hold_reg;
    logic [HOLD_WIDTH-1:0]  hold_next;
    logic [GAIN_W-1:0]      target_reg;
    logic [GAIN_W-1:0]      target_next;
    logic [GAIN_W-1:0]      gain_reg;
    logic [GAIN_W-1:0]      gain_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   out_data_reg;
    logic signed [SW-1:0]   out_data_next;

    logic [SW-1:0]          neg_sample;
    logic [MAG_W-1:0]       mag_in;
    logic signed [SW-1:0]   env_diff;
    logic signed [GAIN_W:0] gain_diff;
    logic [COEF_W-1:0]      coef_env;
    logic [COEF_W-1:0]      coef_gain;
    logic [GAIN_W-1:0]      floor_lim;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [PROD_W-1:0]      coef_sum;
    logic [PROD_W-1:0]      out_sum;
    logic [SW-1:0]          env_full;
    logic [GAIN_W:0]        gain_full;
    logic signed [R_W-1:0]  out_rnd;

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= MAG_W'(RST_THRESHOLD);
            attack_reg   <= RST_ATTACK;
            release_reg  <= RST_RELEASE;
            hold_len_reg <= HOLD_WIDTH'(RST_HOLD);
            floor_reg    <= RST_FLOOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg      <= cfg_data[MAG_W-1:0];
                REG_ATTACK:    attack_reg   <= cfg_data[COEF_W-1:0];
                REG_RELEASE:   release_reg  <= cfg_data[COEF_W-1:0];
                REG_HOLD:      hold_len_reg <= cfg_data[HOLD_WIDTH-1:0];
                REG_FLOOR:     floor_reg    <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // sample magnitude, most negative value saturates
    always_comb
    begin
        neg_sample = -sample_in;
        if (!sample_in[SW-1])
            mag_in = sample_in[MAG_W-1:0];
        else if (neg_sample[SW-1])
            mag_in = '1;
        else
            mag_in = neg_sample[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_in)
        begin
            sample_reg <= sample_in;
            mag_reg    <= mag_in;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        env_diff  = {1'b0, envelope_reg} - {1'b0, mag_reg};
        gain_diff = {1'b0, gain_reg} - {1'b0, target_reg};
        coef_env  = (mag_reg > envelope_reg) ? attack_reg : release_reg;
        coef_gain = (target_reg > gain_reg) ? attack_reg : release_reg;
        case (ctrl.mul_sel)
            MUL_ENV:
            begin
                mul_a = MA_W'(env_diff);
                mul_b = MB_W'(coef_env);
            end
            MUL_GAIN:
            begin
                mul_a = MA_W'(gain_diff);
                mul_b = MB_W'(coef_gain);
            end
            MUL_OUT:
            begin
                mul_a = MA_W'(sample_reg);
                mul_b = MB_W'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel != MUL_NONE)
            prod_reg <= mul_a * mul_b;
    end

    // envelope, hold, gain target and gain update
    always_comb
    begin
        coef_sum      = prod_reg + HALF_COEF;
        env_full      = SW'(mag_reg) + coef_sum[COEF_FRAC +: SW];
        envelope_next = env_full[MAG_W-1:0];
        floor_lim     = (floor_reg > UNITY_GAIN) ? UNITY_GAIN : floor_reg;
        if (envelope_next >= thr_reg)
        begin
            hold_next   = hold_len_reg;
            target_next = UNITY_GAIN;
        end
        else if (hold_reg != '0)
        begin
            hold_next   = hold_reg - HOLD_WIDTH'(1);
            target_next = UNITY_GAIN;
        end
        else
        begin
            hold_next   = hold_reg;
            target_next = floor_lim;
        end
        gain_full = {1'b0, target_reg} + coef_sum[COEF_FRAC +: GAIN_W+1];
        gain_next = gain_full[GAIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            envelope_reg <= '0;
            hold_reg     <= '0;
            gain_reg     <= UNITY_GAIN;
        end
        else
        begin
            if (ctrl.ld_env)
            begin
                envelope_reg <= envelope_next;
                hold_reg     <= hold_next;
            end
            if (ctrl.ld_gain)
                gain_reg <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_env)
            target_reg <= target_next;
    end

    // rounding and saturation of the output beat
    always_comb
    begin
        out_sum = prod_reg + HALF_GAIN;
        out_rnd = $signed(out_sum[PROD_W-1:GAIN_FRAC]);
        if (out_rnd > OUT_MAX)
            out_data_next = OUT_MAX[SW-1:0];
        else if (out_rnd < OUT_MIN)
            out_data_next = OUT_MIN[SW-1:0];
        else
            out_data_next = out_rnd[SW-1:0];
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.ld_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_out)
            out_data_reg <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

@@ dv/audio_noise_gate_unit_tb.sv @@
// self-checking testbench for the audio noise gate: scoreboard class, drivers and monitors
`timescale 1ns / 1ps

module audio_noise_gate_unit_tb;

    import ang_pkg::*;

    localparam int SAMPLE_W        = 24;
    localparam int HOLD_W          = 20;
    localparam int MAG_MAX         = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SMP_MIN         = -(1 << (SAMPLE_W - 1));
    localparam int HOLD_MAX        = (1 << HOLD_W) - 1;
    localparam int UNITY           = int'(UNITY_GAIN);
    localparam int GAIN_MAX        = (1 << GAIN_W) - 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_PRINTS      = 50;

    class gate_scoreboard;
        logic [SAMPLE_W-2:0]        threshold;
        logic [COEF_W-1:0]          attack_coef;
        logic [COEF_W-1:0]          release_coef;
        logic [HOLD_W-1:0]          hold_length;
        logic [GAIN_W-1:0]          floor_gain;
        logic [SAMPLE_W-2:0]        envelope;
        logic [GAIN_W-1:0]          gain;
        logic [HOLD_W-1:0]          hold_count;
        logic signed [SAMPLE_W-1:0] expected_samples[$];
        int                         errors;

        function new();
            threshold    = (SAMPLE_W - 1)'(RST_THRESHOLD);
            attack_coef  = RST_ATTACK;
            release_coef = RST_RELEASE;
            hold_length  = HOLD_W'(RST_HOLD);
            floor_gain   = RST_FLOOR;
            envelope     = '0;
            gain         = UNITY_GAIN;
            hold_count   = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD: threshold    = data[SAMPLE_W-2:0];
                REG_ATTACK:    attack_coef  = data[COEF_W-1:0];
                REG_RELEASE:   release_coef = data[COEF_W-1:0];
                REG_HOLD:      hold_length  = data[HOLD_W-1:0];
                REG_FLOOR:     floor_gain   = data[GAIN_W-1:0];
                default:       ;
            endcase
        endfunction

        // round to nearest, ties up
        function longint shift_round(longint v, int sh);
            return (v + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] s);
            longint x;
            longint mag;
            longint coef;
            longint target;
            longint env_next;
            longint gain_next;
            longint y;
            x   = longint'(s);
            mag = (x < 0) ? -x : x;
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            coef     = (mag > longint'(envelope)) ? longint'(attack_coef) : longint'(release_coef);
            env_next = mag + shift_round((longint'(envelope) - mag) * coef, COEF_FRAC);
            envelope = env_next[SAMPLE_W-2:0];
            if (longint'(envelope) >= longint'(threshold))
            begin
                hold_count = hold_length;
                target     = UNITY;
            end
            else if (hold_count != 0)
            begin
                hold_count = hold_count - 1'b1;
                target     = UNITY;
            end
            else
                target = (longint'(floor_gain) > UNITY) ? UNITY : longint'(floor_gain);
            coef      = (target > longint'(gain)) ? longint'(attack_coef) : longint'(release_coef);
            gain_next = target + shift_round((longint'(gain) - target) * coef, COEF_FRAC);
            gain      = gain_next[GAIN_W-1:0];
            y = shift_round(x * longint'(gain), GAIN_FRAC);
            if (y > MAG_MAX)
                y = MAG_MAX;
            if (y < SMP_MIN)
                y = SMP_MIN;
            expected_samples.push_back(y[SAMPLE_W-1:0]);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("output beat %0d with nothing pending", got));
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("sample_out %0d, predicted %0d", got, want));
            end
        endtask
    endclass

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in  = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;

    gate_scoreboard sb;
    int             idle_pct      = 0;
    int             stall_pct     = 0;
    int             cycle_count   = 0;
    int             hold_off_left = 0;
    logic           hold_off_req  = 1'b0;
    logic           hold_off_seen = 1'b0;

    audio_noise_gate_unit #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .HOLD_WIDTH   (HOLD_W)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            hold_off_left <= 0;
            hold_off_seen <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            out_stall     <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_req != hold_off_seen)
        begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= HOLD_OFF_CYCLES;
            out_stall     <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ports are settled at the falling edge, so beats are taken there
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_input(sample_in);
            if (out_valid && !out_stall)
                sb.check_result(sample_out);
        end
    end

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int width);
        return v | (CFG_DATA_W'($urandom) << width);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return COEF_W'($urandom);
            default: return ~COEF_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_random_settings();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(3))
            0:       v = 0;
            1:       v = MAG_MAX;
            2:       v = $urandom_range(20000);
            default: v = $urandom_range(MAG_MAX);
        endcase
        write_reg(REG_THRESHOLD, with_junk(v, SAMPLE_W - 1));
        write_reg(REG_ATTACK, with_junk(CFG_DATA_W'(pick_coef()), COEF_W));
        write_reg(REG_RELEASE, with_junk(CFG_DATA_W'(pick_coef()), COEF_W));
        case ($urandom_range(3))
            0:       v = 0;
            1:       v = HOLD_MAX;
            2:       v = $urandom_range(40);
            default: v = $urandom_range(HOLD_MAX);
        endcase
        write_reg(REG_HOLD, with_junk(v, HOLD_W));
        case ($urandom_range(3))
            0:       v = 0;
            1:       v = UNITY;
            2:       v = $urandom_range(GAIN_MAX, UNITY + 1);
            default: v = $urandom_range(UNITY);
        endcase
        write_reg(REG_FLOOR, with_junk(v, GAIN_W));
        write_reg(CFG_IDX_W'(REG_FLOOR + 1 + $urandom_range(2)), $urandom);
    endtask

    // loud and quiet bursts around the threshold, with some full-range noise
    task automatic run_random_phase(input int n_items, input bit with_hold_off);
        int                         burst_left;
        bit                         loud;
        int                         mag;
        int                         thr;
        logic signed [SAMPLE_W-1:0] s;
        burst_left = 0;
        loud       = 1'b0;
        for (int i = 0; i < n_items; i++)
        begin
            if (burst_left == 0)
            begin
                loud       = $urandom_range(1);
                burst_left = $urandom_range(30, 1);
            end
            burst_left--;
            thr = int'(sb.threshold);
            if ($urandom_range(9) == 0)
                s = SAMPLE_W'($urandom);
            else
            begin
                mag = loud ? $urandom_range(MAG_MAX, thr) : $urandom_range(thr / 4);
                s   = SAMPLE_W'($urandom_range(1) ? -mag : mag);
            end
            if (with_hold_off && i == 20)
                hold_off_req <= ~hold_off_req;
            send_sample(s);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, field extremes
        send_sample(0);
        send_sample(SAMPLE_W'(MAG_MAX));
        send_sample(SAMPLE_W'(SMP_MIN));
        send_sample(SAMPLE_W'(-1));
        send_sample(1);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        send_sample(0);
        settle();

        // gate always open, floor above unity, unknown indexes ignored
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_ATTACK, 0);
        write_reg(REG_RELEASE, {CFG_DATA_W{1'b1}});
        write_reg(REG_HOLD, 0);
        write_reg(REG_FLOOR, GAIN_MAX);
        for (int i = int'(REG_FLOOR) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_sample(SAMPLE_W'(SMP_MIN));
        send_sample(SAMPLE_W'(MAG_MAX));
        send_sample(100);
        send_sample(SAMPLE_W'(-100));
        settle();

        // highest threshold, zero hold, instant smoothing, zero floor
        write_reg(REG_THRESHOLD, {CFG_DATA_W{1'b1}});
        write_reg(REG_RELEASE, 0);
        write_reg(REG_FLOOR, 0);
        send_sample(SAMPLE_W'(MAG_MAX));
        send_sample(1000);
        send_sample(SAMPLE_W'(SMP_MIN));
        send_sample(SAMPLE_W'(-MAG_MAX));
        send_sample(0);
        settle();

        // hold countdown after the envelope drops
        write_reg(REG_THRESHOLD, 5000);
        write_reg(REG_RELEASE, CFG_DATA_W'(24'h800000));
        write_reg(REG_HOLD, 3);
        write_reg(REG_FLOOR, 32768);
        send_sample(6000);
        repeat (6) send_sample(10);
        send_sample(SAMPLE_W'(-6000));
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    idle_pct  = 7;
                    stall_pct = 7;
                end
            endcase
            program_random_settings();
            run_random_phase(135, ph == 0);
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ audio_noise_gate_unit.f @@
src/ang_pkg.sv
src/ang_datapath.sv
src/audio_noise_gate_unit.sv
dv/audio_noise_gate_unit_tb.sv
